[rtl/core/fst_pkg.sv]
// Shared constants, status codes and types of the free segment table.
package fst_pkg;

  // Default storage shape
  localparam int unsigned SLOTS_DEF     = 64;
  localparam int unsigned ADDR_BITS_DEF = 32;

  // Fixed widths of the request and result fields
  localparam int unsigned CMD_W    = 1;
  localparam int unsigned IO_ADDR_W = 32;
  localparam int unsigned BYTES_W  = 31;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 6;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_RELEASE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FIND    = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  // A first-fit candidate needs size - 1 above request + FIT_MARGIN
  localparam int unsigned FIT_MARGIN = 2;

  // Compare flags of one table entry against the current request
  typedef struct packed {
    logic prev_touch;  // entry ends just before the range
    logic next_touch;  // entry starts just after the range
    logic below;       // range starts below the entry
    logic reach;       // entry starts at or below last + 1
    logic exact;       // entry size equals the requested size
    logic big;         // entry size exceeds request + 3
  } eval_t;

endpackage

[rtl/core/fst_req_if.sv]
// Request channel of the free segment table.
interface fst_req_if;
  logic                            valid;
  logic                            ready;
  logic [fst_pkg::CMD_W-1:0]       command;
  logic [fst_pkg::IO_ADDR_W-1:0]   range_first;
  logic [fst_pkg::IO_ADDR_W-1:0]   range_last;
  logic [fst_pkg::BYTES_W-1:0]     request_bytes;

  modport source (output valid, command, range_first, range_last, request_bytes,
                  input ready);
  modport sink   (input valid, command, range_first, range_last, request_bytes,
                  output ready);
endinterface

[rtl/core/fst_res_if.sv]
// Result channel of the free segment table.
interface fst_res_if;
  logic                            valid;
  logic                            ready;
  logic [fst_pkg::STATUS_W-1:0]    status;
  logic [fst_pkg::IO_ADDR_W-1:0]   segment_start;
  logic [fst_pkg::IO_ADDR_W-1:0]   segment_end;
  logic [fst_pkg::SLOT_W-1:0]      slot_index;

  modport source (output valid, status, segment_start, segment_end, slot_index,
                  input ready);
  modport sink   (input valid, status, segment_start, segment_end, slot_index,
                  output ready);
endinterface

[rtl/core/fst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fst_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/fst_eval.sv]
// Compare unit: tests one table entry against the request held by the sequencer.
module fst_eval #(
  parameter int unsigned ADDR_BITS = fst_pkg::ADDR_BITS_DEF
) (
  input  logic [ADDR_BITS-1:0]                 ent_start_i,
  input  logic [ADDR_BITS-1:0]                 ent_end_i,
  input  logic [ADDR_BITS-1:0]                 first_i,
  input  logic [ADDR_BITS-1:0]                 first_m1_i,
  input  logic                                 first_nz_i,
  input  logic [ADDR_BITS:0]                   last_p1_i,
  input  logic                                 bytes_nz_i,
  input  logic [((ADDR_BITS > 32) ? ADDR_BITS : 32)-1:0] bytes_m1_i,
  input  logic [((ADDR_BITS > 32) ? ADDR_BITS : 32)-1:0] bytes_p2_i,
  output fst_pkg::eval_t                       flags_o
);

  localparam int unsigned CW = (ADDR_BITS > 32) ? ADDR_BITS : 32;

  logic [ADDR_BITS-1:0] size_m1;
  logic [CW-1:0]        size_m1_x;
  logic [ADDR_BITS:0]   start_x;
  logic                 fwd;

  assign size_m1   = ent_end_i - ent_start_i;
  assign size_m1_x = CW'(size_m1);
  assign start_x   = {1'b0, ent_start_i};
  // reversed segments never qualify for a find
  assign fwd       = ent_end_i >= ent_start_i;

  always_comb begin
    flags_o.prev_touch = first_nz_i && (ent_end_i == first_m1_i);
    flags_o.next_touch = start_x == last_p1_i;
    flags_o.below      = first_i < ent_start_i;
    flags_o.reach      = start_x <= last_p1_i;
    flags_o.exact      = fwd && bytes_nz_i && (size_m1_x == bytes_m1_i);
    flags_o.big        = fwd && (size_m1_x > bytes_p2_i);
  end

endmodule

[rtl/core/fst_seq.sv]
// Sequencer: scans, merges and shifts table entries, one RAM read per cycle.
module fst_seq #(
  parameter int unsigned SLOTS     = fst_pkg::SLOTS_DEF,
  parameter int unsigned ADDR_BITS = fst_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request side
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  logic [fst_pkg::CMD_W-1:0]     cmd_i,
  input  logic [ADDR_BITS-1:0]          first_i,
  input  logic [ADDR_BITS-1:0]          last_i,
  input  logic [fst_pkg::BYTES_W-1:0]   bytes_i,
  // result side
  output logic                          res_valid_o,
  input  logic                          res_take_i,
  output logic [fst_pkg::STATUS_W-1:0]  res_status_o,
  output logic [ADDR_BITS-1:0]          res_start_o,
  output logic [ADDR_BITS-1:0]          res_end_o,
  output logic [$clog2(SLOTS)-1:0]      res_slot_o,
  // compare unit
  output logic [ADDR_BITS-1:0]          first_o,
  output logic [ADDR_BITS-1:0]          first_m1_o,
  output logic                          first_nz_o,
  output logic [ADDR_BITS:0]            last_p1_o,
  output logic                          bytes_nz_o,
  output logic [((ADDR_BITS > 32) ? ADDR_BITS : 32)-1:0] bytes_m1_o,
  output logic [((ADDR_BITS > 32) ? ADDR_BITS : 32)-1:0] bytes_p2_o,
  input  fst_pkg::eval_t                flags_i,
  // table RAM
  output logic                          ram_we_o,
  output logic [$clog2(SLOTS)-1:0]      ram_waddr_o,
  output logic [2*ADDR_BITS-1:0]        ram_wdata_o,
  output logic [$clog2(SLOTS)-1:0]      ram_raddr_o,
  input  logic [2*ADDR_BITS-1:0]        ram_rdata_i
);

  localparam int unsigned IW    = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned CW    = (ADDR_BITS > 32) ? ADDR_BITS : 32;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_MERGE  = 3'd2;
  localparam logic [2:0] S_DOWN   = 3'd3;
  localparam logic [2:0] S_UPRIME = 3'd4;
  localparam logic [2:0] S_UP     = 3'd5;
  localparam logic [2:0] S_INS    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic             have_q, have_d;

  logic [fst_pkg::CMD_W-1:0] cmd_q, cmd_d;
  logic [ADDR_BITS-1:0]      first_q, first_d, last_q, last_d, first_m1_q, first_m1_d;
  logic                      first_nz_q, first_nz_d, bytes_nz_q, bytes_nz_d;
  logic [ADDR_BITS:0]        last_p1_q, last_p1_d;
  logic [CW-1:0]             bytes_m1_q, bytes_m1_d, bytes_p2_q, bytes_p2_d;
  logic [CNT_W-1:0]          pick_q, pick_d;
  logic [ADDR_BITS-1:0]      pick_s_q, pick_s_d, pick_e_q, pick_e_d;
  logic [ADDR_BITS-1:0]      cur_s_q, cur_s_d;

  logic [fst_pkg::STATUS_W-1:0] rstat_q, rstat_d;
  logic [ADDR_BITS-1:0]         rstart_q, rstart_d, rend_q, rend_d;
  logic [IW-1:0]                rslot_q, rslot_d;

  logic [ADDR_BITS-1:0] ent_s, ent_e;
  logic [CNT_W-1:0]     idx_p1, idx_m1, pos_p1, pos_p2, raddr;
  logic                 table_full, accept;

  assign ent_s      = ram_rdata_i[2*ADDR_BITS-1:ADDR_BITS];
  assign ent_e      = ram_rdata_i[ADDR_BITS-1:0];
  assign idx_p1     = idx_q + CNT_W'(1);
  assign idx_m1     = idx_q - CNT_W'(1);
  assign pos_p1     = pos_q + CNT_W'(1);
  assign pos_p2     = pos_q + CNT_W'(2);
  assign table_full = used_q == CNT_W'(SLOTS);
  assign accept     = req_valid_i && req_ready_o;

  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    have_d     = have_q;
    cmd_d      = cmd_q;
    first_d    = first_q;
    last_d     = last_q;
    first_m1_d = first_m1_q;
    first_nz_d = first_nz_q;
    last_p1_d  = last_p1_q;
    bytes_nz_d = bytes_nz_q;
    bytes_m1_d = bytes_m1_q;
    bytes_p2_d = bytes_p2_q;
    pick_d     = pick_q;
    pick_s_d   = pick_s_q;
    pick_e_d   = pick_e_q;
    cur_s_d    = cur_s_q;
    rstat_d    = rstat_q;
    rstart_d   = rstart_q;
    rend_d     = rend_q;
    rslot_d    = rslot_q;
    raddr      = idx_p1;
    ram_we_o   = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        raddr       = '0;
        if (accept) begin
          cmd_d      = cmd_i;
          first_d    = first_i;
          last_d     = last_i;
          first_m1_d = first_i - ADDR_BITS'(1);
          first_nz_d = first_i != '0;
          last_p1_d  = {1'b0, last_i} + (ADDR_BITS + 1)'(1);
          bytes_nz_d = bytes_i != '0;
          bytes_m1_d = CW'(bytes_i) - CW'(1);
          bytes_p2_d = CW'(bytes_i) + CW'(fst_pkg::FIT_MARGIN);
          have_d     = 1'b0;
          idx_d      = '0;
          state_d    = S_SCAN;
        end
      end

      S_SCAN: begin
        if (idx_q == used_q) begin
          // end of table
          if (cmd_q == fst_pkg::CMD_FIND) begin
            if (have_q) begin
              rstat_d  = fst_pkg::STAT_OK;
              rstart_d = pick_s_q;
              rend_d   = pick_e_q;
              rslot_d  = pick_q[IW-1:0];
            end else begin
              rstat_d  = fst_pkg::STAT_NOFIT;
              rstart_d = '0;
              rend_d   = '0;
              rslot_d  = '0;
            end
            state_d = S_DONE;
          end else if (table_full) begin
            rstat_d  = fst_pkg::STAT_FULL;
            rstart_d = '0;
            rend_d   = '0;
            rslot_d  = '0;
            state_d  = S_DONE;
          end else begin
            pos_d   = used_q;
            state_d = S_INS;
          end
        end else if (cmd_q == fst_pkg::CMD_FIND) begin
          if (flags_i.exact) begin
            rstat_d  = fst_pkg::STAT_OK;
            rstart_d = ent_s;
            rend_d   = ent_e;
            rslot_d  = idx_q[IW-1:0];
            state_d  = S_DONE;
          end else begin
            if (!have_q && flags_i.big) begin
              have_d   = 1'b1;
              pick_d   = idx_q;
              pick_s_d = ent_s;
              pick_e_d = ent_e;
            end
            idx_d = idx_p1;
          end
        end else begin
          priority if (flags_i.prev_touch) begin
            // next entry is being read this cycle
            pos_d   = idx_q;
            cur_s_d = ent_s;
            state_d = S_MERGE;
          end else if (flags_i.next_touch) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = idx_q[IW-1:0];
            ram_wdata_o = {first_q, ent_e};
            rstat_d     = fst_pkg::STAT_OK;
            rstart_d    = first_q;
            rend_d      = ent_e;
            rslot_d     = idx_q[IW-1:0];
            state_d     = S_DONE;
          end else if (flags_i.below) begin
            if (table_full) begin
              rstat_d  = fst_pkg::STAT_FULL;
              rstart_d = '0;
              rend_d   = '0;
              rslot_d  = '0;
              state_d  = S_DONE;
            end else begin
              pos_d   = idx_q;
              state_d = S_UPRIME;
            end
          end else begin
            idx_d = idx_p1;
          end
        end
      end

      S_MERGE: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = pos_q[IW-1:0];
        rstat_d     = fst_pkg::STAT_OK;
        rstart_d    = cur_s_q;
        rslot_d     = pos_q[IW-1:0];
        if ((pos_p1 < used_q) && flags_i.reach) begin
          // absorb the next entry, then close the gap it leaves
          ram_wdata_o = {cur_s_q, ent_e};
          rend_d      = ent_e;
          raddr       = pos_p2;
          idx_d       = pos_p2;
          state_d     = S_DOWN;
        end else begin
          ram_wdata_o = {cur_s_q, last_q};
          rend_d      = last_q;
          state_d     = S_DONE;
        end
      end

      S_DOWN: begin
        if (idx_q < used_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = idx_m1[IW-1:0];
          ram_wdata_o = ram_rdata_i;
          idx_d       = idx_p1;
        end else begin
          used_d  = used_q - CNT_W'(1);
          state_d = S_DONE;
        end
      end

      S_UPRIME: begin
        raddr   = used_q - CNT_W'(1);
        idx_d   = used_q - CNT_W'(1);
        state_d = S_UP;
      end

      S_UP: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = idx_p1[IW-1:0];
        ram_wdata_o = ram_rdata_i;
        if (idx_q == pos_q) begin
          state_d = S_INS;
        end else begin
          raddr = idx_m1;
          idx_d = idx_m1;
        end
      end

      S_INS: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = pos_q[IW-1:0];
        ram_wdata_o = {first_q, last_q};
        used_d      = used_q + CNT_W'(1);
        rstat_d     = fst_pkg::STAT_OK;
        rstart_d    = first_q;
        rend_d      = last_q;
        rslot_d     = pos_q[IW-1:0];
        state_d     = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign ram_raddr_o  = raddr[IW-1:0];
  assign res_status_o = rstat_q;
  assign res_start_o  = rstart_q;
  assign res_end_o    = rend_q;
  assign res_slot_o   = rslot_q;
  assign first_o      = first_q;
  assign first_m1_o   = first_m1_q;
  assign first_nz_o   = first_nz_q;
  assign last_p1_o    = last_p1_q;
  assign bytes_nz_o   = bytes_nz_q;
  assign bytes_m1_o   = bytes_m1_q;
  assign bytes_p2_o   = bytes_p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      have_q  <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    cmd_q      <= cmd_d;
    first_q    <= first_d;
    last_q     <= last_d;
    first_m1_q <= first_m1_d;
    first_nz_q <= first_nz_d;
    last_p1_q  <= last_p1_d;
    bytes_nz_q <= bytes_nz_d;
    bytes_m1_q <= bytes_m1_d;
    bytes_p2_q <= bytes_p2_d;
    pick_q     <= pick_d;
    pick_s_q   <= pick_s_d;
    pick_e_q   <= pick_e_d;
    cur_s_q    <= cur_s_d;
    rstat_q    <= rstat_d;
    rstart_q   <= rstart_d;
    rend_q     <= rend_d;
    rslot_q    <= rslot_d;
  end

endmodule

[rtl/core/free_segment_table_top.sv]
// Top level of the free segment table: sequencer, compare unit, table RAM, result register.
//
//   channel | dir | handshake     | payload
//   req_i   | in  | valid / ready | command, range_first, range_last, request_bytes
//   res_o   | out | valid / ready | status, segment_start, segment_end, slot_index
//
// A find stops at the first exact fit. A release scans up to the hit, then shifts the
// entries that an insert or an absorbing merge moves. The table is read through its
// single RAM read port, one entry per cycle.
// Reset clears the control state and the entry count; the table RAM is not swept.
// The result register lets a new request enter while a result waits; the sequencer
// holds its finished result until that register is free.
module free_segment_table_top #(
  parameter int unsigned SLOTS     = fst_pkg::SLOTS_DEF,
  parameter int unsigned ADDR_BITS = fst_pkg::ADDR_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  fst_req_if.sink  req_i,
  fst_res_if.source res_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = (ADDR_BITS > 32) ? ADDR_BITS : 32;

  logic                         seq_valid, seq_take;
  logic [fst_pkg::STATUS_W-1:0] seq_status;
  logic [ADDR_BITS-1:0]         seq_start, seq_end;
  logic [IW-1:0]                seq_slot;

  logic [ADDR_BITS-1:0] first_q, first_m1, last_in, first_in;
  logic                 first_nz, bytes_nz;
  logic [ADDR_BITS:0]   last_p1;
  logic [CW-1:0]        bytes_m1, bytes_p2;
  fst_pkg::eval_t       flags;

  logic                   ram_we;
  logic [IW-1:0]          ram_waddr, ram_raddr;
  logic [2*ADDR_BITS-1:0] ram_wdata, ram_rdata;

  logic                          out_valid_q;
  logic [fst_pkg::STATUS_W-1:0]  out_status_q;
  logic [fst_pkg::IO_ADDR_W-1:0] out_start_q, out_end_q;
  logic [fst_pkg::SLOT_W-1:0]    out_slot_q;

  // addresses live modulo 2^ADDR_BITS inside the table
  assign first_in = ADDR_BITS'(req_i.range_first);
  assign last_in  = ADDR_BITS'(req_i.range_last);

  fst_seq #(
    .SLOTS     (SLOTS),
    .ADDR_BITS (ADDR_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_ready_o  (req_i.ready),
    .cmd_i        (req_i.command),
    .first_i      (first_in),
    .last_i       (last_in),
    .bytes_i      (req_i.request_bytes),
    .res_valid_o  (seq_valid),
    .res_take_i   (seq_take),
    .res_status_o (seq_status),
    .res_start_o  (seq_start),
    .res_end_o    (seq_end),
    .res_slot_o   (seq_slot),
    .first_o      (first_q),
    .first_m1_o   (first_m1),
    .first_nz_o   (first_nz),
    .last_p1_o    (last_p1),
    .bytes_nz_o   (bytes_nz),
    .bytes_m1_o   (bytes_m1),
    .bytes_p2_o   (bytes_p2),
    .flags_i      (flags),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  fst_eval #(
    .ADDR_BITS (ADDR_BITS)
  ) u_eval (
    .ent_start_i (ram_rdata[2*ADDR_BITS-1:ADDR_BITS]),
    .ent_end_i   (ram_rdata[ADDR_BITS-1:0]),
    .first_i     (first_q),
    .first_m1_i  (first_m1),
    .first_nz_i  (first_nz),
    .last_p1_i   (last_p1),
    .bytes_nz_i  (bytes_nz),
    .bytes_m1_i  (bytes_m1),
    .bytes_p2_i  (bytes_p2),
    .flags_o     (flags)
  );

  fst_ram #(
    .WIDTH (2 * ADDR_BITS),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // load the result register when it is empty or being drained
  assign seq_take = seq_valid && (!out_valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_take) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_take) begin
      out_status_q <= seq_status;
      out_start_q  <= fst_pkg::IO_ADDR_W'(seq_start);
      out_end_q    <= fst_pkg::IO_ADDR_W'(seq_end);
      out_slot_q   <= fst_pkg::SLOT_W'(seq_slot);
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.status        = out_status_q;
  assign res_o.segment_start = out_start_q;
  assign res_o.segment_end   = out_end_q;
  assign res_o.slot_index    = out_slot_q;

endmodule

[tb/sv/free_segment_table_top_tb.sv]
// Self-checking testbench of the free segment table: directed and random requests, mirrored table.
module free_segment_table_top_tb;
  import fst_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RANDOM_REQS  = 650;

  typedef logic [IO_ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    addr_t              range_first;
    addr_t              range_last;
    logic [BYTES_W-1:0] request_bytes;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    addr_t               seg_start;
    addr_t               seg_end;
    logic [SLOT_W-1:0]   slot_index;
  } result_t;

  // Mirror of the sorted free list and the results it still owes.
  class free_list_mirror;
    addr_t       seg_first [SLOTS_DEF];
    addr_t       seg_last  [SLOTS_DEF];
    int unsigned seg_count;
    result_t     expected_results [$];
    int unsigned failures;

    function new();
      seg_count = 0;
      failures  = 0;
    endfunction

    function result_t report(logic [STATUS_W-1:0] status, int unsigned slot);
      result_t r;
      r.status     = status;
      r.seg_start  = '0;
      r.seg_end    = '0;
      r.slot_index = '0;
      if (status == STAT_OK && slot < seg_count) begin
        r.seg_start  = seg_first[slot];
        r.seg_end    = seg_last[slot];
        r.slot_index = SLOT_W'(slot);
      end
      return r;
    endfunction

    function result_t insert_segment(int unsigned pos, addr_t f, addr_t l);
      int unsigned i;
      if (seg_count >= SLOTS_DEF) return report(STAT_FULL, 0);
      for (i = seg_count; i > pos; i--) begin
        seg_first[i] = seg_first[i-1];
        seg_last[i]  = seg_last[i-1];
      end
      seg_first[pos] = f;
      seg_last[pos]  = l;
      seg_count++;
      return report(STAT_OK, pos);
    endfunction

    function void remove_segment(int unsigned pos);
      int unsigned i;
      for (i = pos; i + 1 < seg_count; i++) begin
        seg_first[i] = seg_first[i+1];
        seg_last[i]  = seg_last[i+1];
      end
      seg_count--;
    endfunction

    function result_t release_range(addr_t f, addr_t l);
      int unsigned i;
      for (i = 0; i < seg_count; i++) begin
        if (f != '0 && seg_last[i] == f - addr_t'(1)) begin
          seg_last[i] = l;
          // absorb the next segment when it now touches or overlaps
          if (i + 1 < seg_count &&
              (seg_first[i+1] == '0 || seg_first[i+1] - addr_t'(1) <= l)) begin
            seg_last[i] = seg_last[i+1];
            remove_segment(i + 1);
          end
          return report(STAT_OK, i);
        end
        if (seg_first[i] != '0 && seg_first[i] - addr_t'(1) == l) begin
          seg_first[i] = f;
          return report(STAT_OK, i);
        end
        if (f < seg_first[i]) return insert_segment(i, f, l);
      end
      return insert_segment(seg_count, f, l);
    endfunction

    function result_t find_fit(logic [BYTES_W-1:0] n);
      int unsigned     i;
      bit              have;
      int unsigned     pick;
      longint unsigned span;
      have = 1'b0;
      pick = 0;
      for (i = 0; i < seg_count; i++) begin
        if (seg_last[i] < seg_first[i]) continue;
        span = longint'(seg_last[i] - seg_first[i]);
        if (n != '0 && span == longint'(n) - 1) return report(STAT_OK, i);
        if (!have && span > longint'(n) + FIT_MARGIN) begin
          have = 1'b1;
          pick = i;
        end
      end
      return have ? report(STAT_OK, pick) : report(STAT_NOFIT, 0);
    endfunction

    function void note_request(request_t rq);
      if (rq.command == CMD_RELEASE)
        expected_results.push_back(release_range(rq.range_first, rq.range_last));
      else
        expected_results.push_back(find_fit(rq.request_bytes));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d start %h end %h slot %0d",
               got.status, got.seg_start, got.seg_end, got.slot_index);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        failures++;
      end
      if (got.seg_start !== want.seg_start) begin
        $error("segment_start: expected %h, actual %h", want.seg_start, got.seg_start);
        failures++;
      end
      if (got.seg_end !== want.seg_end) begin
        $error("segment_end: expected %h, actual %h", want.seg_end, got.seg_end);
        failures++;
      end
      if (got.slot_index !== want.slot_index) begin
        $error("slot_index: expected %0d, actual %0d", want.slot_index, got.slot_index);
        failures++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  fst_req_if req_if ();
  fst_res_if res_if ();

  free_segment_table_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  free_list_mirror mirror = new();
  int unsigned     burst_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(request_t rq);
    int unsigned gap;
    if (burst_left != 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 40);
    end
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.command       <= rq.command;
    req_if.range_first   <= rq.range_first;
    req_if.range_last    <= rq.range_last;
    req_if.request_bytes <= rq.request_bytes;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    mirror.note_request(rq);
  endtask

  task automatic send_release(addr_t f, addr_t l);
    request_t rq;
    rq.command       = CMD_RELEASE;
    rq.range_first   = f;
    rq.range_last    = l;
    rq.request_bytes = BYTES_W'($urandom());
    send_request(rq);
  endtask

  task automatic send_find(logic [BYTES_W-1:0] n);
    request_t rq;
    rq.command       = CMD_FIND;
    rq.range_first   = $urandom();
    rq.range_last    = $urandom();
    rq.request_bytes = n;
    send_request(rq);
  endtask

  // Random request shaped around the segments the table currently holds.
  function automatic request_t draw_request();
    request_t    rq;
    int unsigned k;
    int unsigned pick;
    addr_t       span;
    rq.command       = CMD_RELEASE;
    rq.range_first   = $urandom();
    rq.range_last    = $urandom();
    rq.request_bytes = BYTES_W'($urandom());
    k    = (mirror.seg_count != 0) ? $urandom_range(0, mirror.seg_count - 1) : 0;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 60) begin
      if (mirror.seg_count == 0 || pick < 30) begin
        rq.range_last = rq.range_first + $urandom_range(0, 4000);
      end else if (pick < 50) begin
        // extend a segment upward, sometimes far enough to swallow neighbors
        rq.range_first = mirror.seg_last[k] + addr_t'(1);
        rq.range_last  = rq.range_first +
                         ((pick < 45) ? $urandom_range(0, 300) : $urandom_range(0, 1 << 22));
      end else if (pick < 65) begin
        rq.range_last  = mirror.seg_first[k] - addr_t'(1);
        rq.range_first = rq.range_last - $urandom_range(0, 300);
      end else if (pick < 78 && mirror.seg_count >= 2) begin
        // close the gap between two neighbors, exactly or with overlap
        k = $urandom_range(0, mirror.seg_count - 2);
        rq.range_first = mirror.seg_last[k] + addr_t'(1);
        rq.range_last  = (pick < 73) ? mirror.seg_first[k+1] - addr_t'(1)
                                     : mirror.seg_first[k+1] + $urandom_range(0, 64);
      end else if (pick < 88) begin
        // keep the fully random range
      end else if (pick < 94) begin
        rq.range_last = rq.range_first - $urandom_range(1, 500);
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            rq.range_first = '0;
            rq.range_last  = $urandom_range(0, 300);
          end
          1: begin
            rq.range_last  = '1;
            rq.range_first = addr_t'('1) - $urandom_range(0, 300);
          end
          default: begin
            rq.range_first = '0;
            rq.range_last  = '1;
          end
        endcase
      end
    end else begin
      rq.command = CMD_FIND;
      span = mirror.seg_last[k] - mirror.seg_first[k];
      if (mirror.seg_count == 0 || pick < 15) begin
        // keep the random size
      end else if (pick < 45) begin
        rq.request_bytes = BYTES_W'(span + addr_t'(1));
      end else if (pick < 65) begin
        rq.request_bytes = BYTES_W'(span - addr_t'(FIT_MARGIN + 1) - $urandom_range(0, 20));
      end else if (pick < 75) begin
        rq.request_bytes = BYTES_W'(span - addr_t'(FIT_MARGIN));
      end else if (pick < 85) begin
        rq.request_bytes = '0;
      end else if (pick < 92) begin
        rq.request_bytes = '1;
      end
    end
    return rq;
  endfunction

  initial begin : result_backpressure
    int unsigned span;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      span = $urandom_range(0, 9) == 0 ? $urandom_range(50, 150) : $urandom_range(1, 20);
      res_if.ready <= 1'b1;
      repeat (span) @(posedge clk_i);
      span = pick_gap();
      if (span != 0) begin
        res_if.ready <= 1'b0;
        repeat (span) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      mirror.check_result('{status:     res_if.status,
                            seg_start:  res_if.segment_start,
                            seg_end:    res_if.segment_end,
                            slot_index: res_if.slot_index});
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned n;
    rst_ni               <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.command       <= CMD_RELEASE;
    req_if.range_first   <= '0;
    req_if.range_last    <= '0;
    req_if.request_bytes <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_find(BYTES_W'(5));                     // empty table
    send_release(32'd100, 32'd199);             // into an empty table
    send_release(32'd300, 32'd399);             // append past the last segment
    send_release(32'd200, 32'd250);             // grow the first segment upward
    send_release(32'd251, 32'd299);             // grow and absorb the next one
    send_release(32'd50, 32'd99);               // grow a segment downward
    send_release(32'd10, 32'd20);               // insert in front
    send_release(32'd0, 32'd5);                 // insert at address zero
    send_release(32'd6, 32'd9);                 // bridge two segments exactly
    send_release(32'd21, 32'd60);               // absorb an overlapping neighbor
    send_release(32'hFFFF_FF00, 32'hFFFF_FFFF); // top of the address space
    send_release(32'hFFFF_FE00, 32'hFFFF_FEFF); // grows the top segment downward
    send_release(32'd1000, 32'd900);            // reversed range
    send_release(32'd2000, 32'd2007);
    send_find(BYTES_W'(8));                     // exact size
    send_find('0);                              // zero request
    send_find(BYTES_W'(5));                     // boundary: size - 1 equals request + 2, not enough
    send_find(BYTES_W'(6));                     // size - 1 just below request + 2: not large enough
    send_find('1);                              // no fit
    send_find(BYTES_W'(400));
    send_release(32'hFFFF_FFF0, 32'hFFFF_FEFF); // reversed, near the top

    for (n = 0; n < RANDOM_REQS; n++) send_request(draw_request());
    req_if.valid <= 1'b0;

    while (mirror.expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mirror.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/fst_pkg.sv
rtl/core/fst_req_if.sv
rtl/core/fst_res_if.sv
rtl/core/fst_ram.sv
rtl/core/fst_eval.sv
rtl/core/fst_seq.sv
rtl/core/free_segment_table_top.sv
tb/sv/free_segment_table_top_tb.sv
